FILE: rtl/first_fit_free_run_finder_unit_macros.svh
// ----------------------------------------------------------------------------
// first fit free run finder assertion macros
// concurrent assertion helpers, empty in synthesis builds
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_FREE_RUN_FINDER_UNIT_MACROS_SVH
`define FIRST_FIT_FREE_RUN_FINDER_UNIT_MACROS_SVH
`ifndef SYNTH
`define FFRF_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("ffrf assertion failed");
`define FFRF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  `FFRF_ASSERT(lbl, clk, rstn, (ante) |-> (cons))
`else
`define FFRF_ASSERT(lbl, clk, rstn, prop)
`define FFRF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/ffrf_pkg.sv
// ----------------------------------------------------------------------------
// ffrf_pkg
// shared types, constants and node merge for the free run finder
// ----------------------------------------------------------------------------
package ffrf_pkg;

  localparam int SLOT_W = 12;
  localparam int CNT_W  = SLOT_W + 1;
  localparam int ADDR_W = SLOT_W + 1;
  localparam logic [CNT_W-1:0]  UNIVERSE  = CNT_W'(1) << SLOT_W;
  localparam logic [ADDR_W-1:0] ROOT_ADDR = ADDR_W'(1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = '1;

  typedef struct packed {
    logic [CNT_W-1:0] head;
    logic [CNT_W-1:0] tail;
    logic [CNT_W-1:0] best;
  } node_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP_LEAF,
    ST_UP_MERGE,
    ST_Q_ROOT,
    ST_Q_A,
    ST_Q_B
  } state_e;

  function automatic node_t node_merge(node_t a, node_t b, logic [CNT_W-1:0] len);
    node_t r;
    logic [CNT_W-1:0] mid;
    mid    = a.tail + b.head;
    r.head = (a.head == len) ? len + b.head : a.head;
    r.tail = (b.tail == len) ? len + a.tail : b.tail;
    r.best = (a.best > b.best) ? a.best : b.best;
    if (mid > r.best) r.best = mid;
    return r;
  endfunction

endpackage

FILE: rtl/ffrf_node_ram.sv
// ----------------------------------------------------------------------------
// ffrf_node_ram
// run summary node store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ffrf_node_ram (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [ffrf_pkg::ADDR_W-1:0] waddr_i,
  input  ffrf_pkg::node_t            wdata_i,
  input  logic [ffrf_pkg::ADDR_W-1:0] raddr_i,
  output ffrf_pkg::node_t            rdata_o
);
  import ffrf_pkg::*;

  node_t mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: rtl/first_fit_free_run_finder_unit.sv
// ----------------------------------------------------------------------------
// first_fit_free_run_finder_unit
// occupied slot set with a run summary tree, answers first fit free runs
// ----------------------------------------------------------------------------
// insert/remove: leaf update, then one tree level per cycle on the node ram up to the root
// query: root check, then per level a read of both children (Q_A, Q_B); zero length answers straight from idle
// run_start_o is shown for one cycle with valid_o; busy high while working
// after reset a clearing sweep over node addresses 1 to 8191 fills the node ram, busy meanwhile
// ----------------------------------------------------------------------------
module first_fit_free_run_finder_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  opcode_i,
  input  logic [ffrf_pkg::SLOT_W-1:0] slot_i,
  input  logic [ffrf_pkg::CNT_W-1:0]  run_length_i,
  output logic                        valid_o,
  output logic [ffrf_pkg::CNT_W-1:0]  run_start_o
);
  import ffrf_pkg::*;
  `include "first_fit_free_run_finder_unit_macros.svh"

  state_e               state_q, state_d;
  op_e                  op_q, op_d;
  logic [CNT_W-1:0]     k_q, k_d;
  logic [ADDR_W-1:0]    cur_q, cur_d;
  node_t                cur_val_q, cur_val_d;
  logic [CNT_W-1:0]     len_q, len_d;
  logic [SLOT_W-1:0]    lo_q, lo_d;
  node_t                a_q, a_d;
  logic [ADDR_W-1:0]    clr_cnt_q, clr_cnt_d;
  logic [CNT_W-1:0]     clr_pow_q, clr_pow_d;
  logic [CNT_W-1:0]     clr_len_q, clr_len_d;
  logic                 valid_q, valid_d;
  logic [CNT_W-1:0]     res_q, res_d;

  logic                 mem_we;
  logic [ADDR_W-1:0]    mem_waddr, mem_raddr;
  node_t                mem_wdata, mem_rdata;

  node_t                leaf_new, par_val, lft, rgt;
  logic                 leaf_free;
  logic [ADDR_W-1:0]    par_addr, nxt_node;
  logic [CNT_W-1:0]     half, span;
  logic [SLOT_W-1:0]    nxt_lo;

  ffrf_node_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= ROOT_ADDR;
      clr_pow_q <= CNT_W'(1);
      clr_len_q <= UNIVERSE;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_cnt_q <= clr_cnt_d;
      clr_pow_q <= clr_pow_d;
      clr_len_q <= clr_len_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    k_q       <= k_d;
    cur_q     <= cur_d;
    cur_val_q <= cur_val_d;
    len_q     <= len_d;
    lo_q      <= lo_d;
    a_q       <= a_d;
    res_q     <= res_d;
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    k_d       = k_q;
    cur_d     = cur_q;
    cur_val_d = cur_val_q;
    len_d     = len_q;
    lo_d      = lo_q;
    a_d       = a_q;
    clr_cnt_d = clr_cnt_q;
    clr_pow_d = clr_pow_q;
    clr_len_d = clr_len_q;
    valid_d   = 1'b0;
    res_d     = res_q;
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = cur_val_q;
    mem_raddr = ROOT_ADDR;

    leaf_free = (mem_rdata.best != '0);
    leaf_new  = leaf_free ? node_t'('0)
                          : node_t'{head: CNT_W'(1), tail: CNT_W'(1), best: CNT_W'(1)};
    lft       = cur_q[0] ? mem_rdata : cur_val_q;
    rgt       = cur_q[0] ? cur_val_q : mem_rdata;
    par_val   = node_merge(lft, rgt, len_q);
    par_addr  = cur_q >> 1;
    half      = len_q >> 1;
    span      = a_q.tail + mem_rdata.head;
    nxt_node  = {cur_q[ADDR_W-2:0], 1'b0};
    nxt_lo    = lo_q;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        if (clr_cnt_q == ADDR_W'(clr_pow_q)) begin
          mem_wdata = '{head: '0, tail: clr_len_q - 1'b1, best: clr_len_q - 1'b1};
        end else begin
          mem_wdata = '{head: clr_len_q, tail: clr_len_q, best: clr_len_q};
        end
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (((clr_cnt_q + 1'b1) & clr_cnt_q) == '0) begin
          clr_pow_d = clr_pow_q << 1;
          clr_len_d = clr_len_q >> 1;
        end
        if (clr_cnt_q == LAST_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          case (opcode_i)
            OP_INSERT, OP_REMOVE: begin
              if (slot_i != '0) begin
                op_d      = op_e'(opcode_i);
                cur_d     = {1'b1, slot_i};
                mem_raddr = {1'b1, slot_i};
                state_d   = ST_UP_LEAF;
              end
            end
            OP_QUERY: begin
              if (run_length_i == '0) begin
                valid_d = 1'b1;
                res_d   = CNT_W'(1);
              end else begin
                k_d       = run_length_i;
                mem_raddr = ROOT_ADDR;
                state_d   = ST_Q_ROOT;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_UP_LEAF: begin
        if ((op_q == OP_INSERT && leaf_free) || (op_q == OP_REMOVE && !leaf_free)) begin
          mem_we    = 1'b1;
          mem_waddr = cur_q;
          mem_wdata = leaf_new;
          cur_val_d = leaf_new;
          mem_raddr = cur_q ^ ADDR_W'(1);
          len_d     = CNT_W'(1);
          state_d   = ST_UP_MERGE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_UP_MERGE: begin
        mem_we    = 1'b1;
        mem_waddr = par_addr;
        mem_wdata = par_val;
        cur_d     = par_addr;
        cur_val_d = par_val;
        len_d     = len_q << 1;
        mem_raddr = par_addr ^ ADDR_W'(1);
        if (par_addr == ROOT_ADDR) begin
          state_d = ST_IDLE;
        end
      end
      ST_Q_ROOT: begin
        if (mem_rdata.best < k_q) begin
          valid_d = 1'b1;
          res_d   = UNIVERSE - mem_rdata.tail;
          state_d = ST_IDLE;
        end else begin
          cur_d     = ROOT_ADDR;
          lo_d      = '0;
          len_d     = UNIVERSE;
          mem_raddr = {ROOT_ADDR[ADDR_W-2:0], 1'b0};
          state_d   = ST_Q_A;
        end
      end
      ST_Q_A: begin
        a_d       = mem_rdata;
        mem_raddr = {cur_q[ADDR_W-2:0], 1'b1};
        state_d   = ST_Q_B;
      end
      ST_Q_B: begin
        if (a_q.best >= k_q) begin
          nxt_node = {cur_q[ADDR_W-2:0], 1'b0};
          nxt_lo   = lo_q;
        end else begin
          nxt_node = {cur_q[ADDR_W-2:0], 1'b1};
          nxt_lo   = lo_q + SLOT_W'(half);
        end
        cur_d     = nxt_node;
        lo_d      = nxt_lo;
        len_d     = half;
        mem_raddr = {nxt_node[ADDR_W-2:0], 1'b0};
        if (a_q.best < k_q && span >= k_q) begin
          valid_d = 1'b1;
          res_d   = {1'b0, lo_q} + half - a_q.tail;
          state_d = ST_IDLE;
        end else if (half == CNT_W'(1)) begin
          valid_d = 1'b1;
          res_d   = {1'b0, nxt_lo};
          state_d = ST_IDLE;
        end else begin
          state_d = ST_Q_A;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign valid_o     = valid_q;
  assign run_start_o = res_q;

  `FFRF_ASSERT_IMP(a_wr_nonzero, clk_i, rst_ni, mem_we, mem_waddr != '0)
  `FFRF_ASSERT_IMP(a_res_nonzero, clk_i, rst_ni, valid_o, run_start_o != '0)
  `FFRF_ASSERT_IMP(a_desc_not_leaf, clk_i, rst_ni, state_q == ST_Q_B, len_q > CNT_W'(1))
  `FFRF_ASSERT_IMP(a_clear_busy, clk_i, rst_ni, state_q == ST_CLEAR, busy)
endmodule

FILE: sim/tb_first_fit_free_run_finder_unit.sv
// ----------------------------------------------------------------------------
// tb_first_fit_free_run_finder_unit
// drives insert, remove and query words in random bursts, keeps its own
// occupied slot bitmap, scans it for the first fit run of each untyped query
// and compares every run_start_o word against the oldest expected start
// ----------------------------------------------------------------------------
module tb_first_fit_free_run_finder_unit;
  import ffrf_pkg::*;

  localparam logic [1:0] OP_UNUSED  = 2'd3;
  localparam int         NUM_SLOTS  = 4096;
  localparam int         RAND_WORDS = 900;

  typedef struct {
    logic [1:0]       op;
    logic [SLOT_W-1:0] slot;
    logic [CNT_W-1:0] k;
    bit               typed;
    logic [CNT_W-1:0] start_exp;
  } word_t;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic [1:0]        opcode_i;
  logic [SLOT_W-1:0] slot_i;
  logic [CNT_W-1:0]  run_length_i;
  logic              valid_o;
  logic [CNT_W-1:0]  run_start_o;

  bit               slot_taken [NUM_SLOTS];
  logic [CNT_W-1:0] start_q [$];
  int               mismatches;
  word_t            dir_words [$];

  first_fit_free_run_finder_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .opcode_i    (opcode_i),
    .slot_i      (slot_i),
    .run_length_i(run_length_i),
    .valid_o     (valid_o),
    .run_start_o (run_start_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic logic [CNT_W-1:0] first_fit_start(logic [CNT_W-1:0] k);
    int run;
    run = 0;
    if (k == 0) return CNT_W'(1);
    for (int i = 1; i < NUM_SLOTS; i++) begin
      if (slot_taken[i]) run = 0;
      else run++;
      if (run >= k) return CNT_W'(i - run + 1);
    end
    return CNT_W'(NUM_SLOTS - run);
  endfunction

  // update the bitmap, queue the expected start for queries
  function automatic void apply_word(word_t w);
    logic [CNT_W-1:0] d;
    case (w.op)
      OP_INSERT: begin
        if (w.slot != 0) slot_taken[w.slot] = 1'b1;
      end
      OP_REMOVE: begin
        if (w.slot != 0) slot_taken[w.slot] = 1'b0;
      end
      OP_QUERY: begin
        d = first_fit_start(w.k);
        start_q = {start_q, (w.typed ? w.start_exp : d)};
      end
      default: ;
    endcase
  endfunction

  function automatic void add_dir_word(word_t w);
    dir_words = {dir_words, w};
  endfunction

  task automatic send_word(word_t w, bit hold);
    start        <= 1'b1;
    opcode_i     <= w.op;
    slot_i       <= w.slot;
    run_length_i <= w.k;
    do @(posedge clk_i); while (busy);
    apply_word(w);
    if (!hold) start <= 1'b0;
  endtask

  function automatic word_t mk(logic [1:0] op, int slot, int k, bit typed = 0, int e = 0);
    word_t w;
    w.op        = op;
    w.slot      = SLOT_W'(slot);
    w.k         = CNT_W'(k);
    w.typed     = typed;
    w.start_exp = CNT_W'(e);
    return w;
  endfunction

  function automatic word_t rand_word();
    word_t w;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 40) w.op = OP_INSERT;
    else if (r < 65) w.op = OP_REMOVE;
    else if (r < 97) w.op = OP_QUERY;
    else w.op = OP_UNUSED;
    // mostly a dense low window so gaps stay short and interesting
    r = $urandom_range(0, 99);
    if (r < 70) w.slot = SLOT_W'($urandom_range(0, 63));
    else if (r < 85) w.slot = SLOT_W'($urandom_range(4032, 4095));
    else w.slot = SLOT_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 70) w.k = CNT_W'($urandom_range(0, 12));
    else if (r < 85) w.k = CNT_W'($urandom_range(13, 4096));
    else w.k = CNT_W'($urandom);
    w.typed     = 0;
    w.start_exp = '0;
    return w;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (start_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: run_start %0d", run_start_o);
      end else begin
        if (run_start_o !== start_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("run_start mismatch: expected %0d, actual %0d", start_q[0], run_start_o);
        end
        void'(start_q.pop_front());
      end
    end
  end

  initial begin
    #4000000;
    $display("first_fit_free_run_finder_unit regression: fail");
    $finish;
  end

  initial begin
    int burst;
    int sent;
    int waited;
    int gap;
    mismatches   = 0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    opcode_i     = '0;
    slot_i       = '0;
    run_length_i = '0;
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;
    slot_taken[0] = 1'b1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_dir_word(mk(OP_QUERY, 0, 1, 1, 1));
    add_dir_word(mk(OP_QUERY, 0, 0, 1, 1));
    add_dir_word(mk(OP_QUERY, 0, 4096, 1, 1));
    add_dir_word(mk(OP_QUERY, 0, 8191, 1, 1));
    add_dir_word(mk(OP_INSERT, 4095, 0));
    add_dir_word(mk(OP_QUERY, 0, 4096, 1, 4096));
    add_dir_word(mk(OP_QUERY, 0, 4094, 1, 1));
    add_dir_word(mk(OP_QUERY, 0, 4095, 1, 4096));
    add_dir_word(mk(OP_INSERT, 1, 0));
    add_dir_word(mk(OP_INSERT, 1, 0));
    add_dir_word(mk(OP_REMOVE, 2, 0));
    add_dir_word(mk(OP_INSERT, 0, 0));
    add_dir_word(mk(OP_REMOVE, 0, 0));
    add_dir_word(mk(OP_QUERY, 0, 1, 1, 2));
    add_dir_word(mk(OP_UNUSED, 4095, 8191));
    add_dir_word(mk(OP_REMOVE, 4095, 0));
    add_dir_word(mk(OP_INSERT, 2048, 0));
    add_dir_word(mk(OP_QUERY, 0, 2048, 1, 2049));
    add_dir_word(mk(OP_QUERY, 0, 2046, 1, 2));
    add_dir_word(mk(OP_QUERY, 0, 2047));
    add_dir_word(mk(OP_REMOVE, 1, 0));
    add_dir_word(mk(OP_REMOVE, 2048, 0));
    add_dir_word(mk(OP_QUERY, 0, 4095, 1, 1));

    @(posedge clk_i);
    // random words follow directly, so start stays high
    foreach (dir_words[i]) send_word(dir_words[i], 1'b1);

    sent = 0;
    while (sent < RAND_WORDS) begin
      burst = $urandom_range(1, 24);
      gap   = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 30) : 0;
      for (int j = 0; j < burst && sent < RAND_WORDS; j++) begin
        send_word(rand_word(), (j != burst - 1 || gap == 0) && sent != RAND_WORDS - 1);
        sent++;
      end
      if (gap != 0) repeat (gap) @(posedge clk_i);
    end

    waited = 0;
    while (start_q.size() != 0 && waited < 10000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (40) @(posedge clk_i);
    if (mismatches == 0 && start_q.size() == 0) begin
      $display("first_fit_free_run_finder_unit regression: pass");
    end else begin
      $display("first_fit_free_run_finder_unit regression: fail");
    end
    $finish;
  end

endmodule
